// File: rtl/jcsp_pkg.sv
// ----------------------------------------------------------------------------
// jcsp_pkg
// Shared types, character codes and the byte-level scan step for the
// JSON-with-comments lexical prescan.
// ----------------------------------------------------------------------------
package jcsp_pkg;

    // Lexical position inside the text
    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_STRING     = 3'd5,
        MODE_ESCAPE     = 3'd6,
        MODE_ESC_CR     = 3'd7
    } t_mode;

    // Status codes, first error wins
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_COMMENT = 2'd1,
        ERR_NEWLINE = 2'd2,
        ERR_STRING  = 2'd3
    } t_err;

    // One result item
    typedef struct packed {
        t_err status;
        logic final_verdict;
    } t_result;

    // Outcome of scanning one byte
    typedef struct packed {
        t_mode mode;
        logic  raw_newline;
    } t_step;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int unsigned TDATA_W = 8;

    // Byte in normal text: only a quote or a slash matters
    function automatic t_mode normal_byte(input logic [7:0] c);
        t_mode m;
        if (c == CH_SLASH) begin
            m = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
            m = MODE_STRING;
        end else begin
            m = MODE_NORMAL;
        end
        return m;
    endfunction

    // Byte as string content; a raw LF or CR is flagged
    function automatic t_step string_byte(input logic [7:0] c);
        t_step s;
        s.raw_newline = 1'b0;
        if (c == CH_BSLASH) begin
            s.mode = MODE_ESCAPE;
        end else if (c == CH_QUOTE) begin
            s.mode = MODE_NORMAL;
        end else begin
            s.mode        = MODE_STRING;
            s.raw_newline = (c == CH_LF) || (c == CH_CR);
        end
        return s;
    endfunction

    // Advance the lexical mode by one byte
    function automatic t_step scan_step(input t_mode mode, input logic [7:0] c);
        t_step s;
        s.raw_newline = 1'b0;
        s.mode        = mode;
        unique case (mode)
            MODE_NORMAL: begin
                s.mode = normal_byte(c);
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    s.mode = MODE_LINE;
                end else if (c == CH_STAR) begin
                    s.mode = MODE_BLOCK;
                end else begin
                    s.mode = normal_byte(c);
                end
            end
            MODE_LINE: begin
                s.mode = ((c == CH_LF) || (c == CH_CR)) ? MODE_NORMAL : MODE_LINE;
            end
            MODE_BLOCK: begin
                s.mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
            MODE_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    s.mode = MODE_NORMAL;
                end else begin
                    s.mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
                end
            end
            MODE_STRING: begin
                s = string_byte(c);
            end
            MODE_ESCAPE: begin
                s.mode = (c == CH_CR) ? MODE_ESC_CR : MODE_STRING;
            end
            MODE_ESC_CR: begin
                // LF right after an escaped CR is part of the escape
                if (c == CH_LF) begin
                    s.mode = MODE_STRING;
                end else begin
                    s = string_byte(c);
                end
            end
        endcase
        return s;
    endfunction

endpackage

// File: rtl/jcsp_scan.sv
// ----------------------------------------------------------------------------
// jcsp_scan
// Lexical mode and sticky error registers; produces the status for each
// accepted byte and clears itself after the last byte of a text.
// ----------------------------------------------------------------------------
module jcsp_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_text_byte,
    input  logic               i_is_last,
    output jcsp_pkg::t_result  o_result
);
    import jcsp_pkg::*;

    t_mode r_mode;
    t_mode n_mode;
    t_err  r_err;
    t_err  n_err;
    t_step step;
    t_mode scan_mode;
    t_err  scan_err;
    t_err  final_err;

    // Next state: scan the byte unless an error already froze the text
    always_comb begin
        step = scan_step(r_mode, i_text_byte);
        if (r_err == ERR_NONE) begin
            scan_mode = step.mode;
            scan_err  = step.raw_newline ? ERR_NEWLINE : ERR_NONE;
        end else begin
            scan_mode = r_mode;
            scan_err  = r_err;
        end
        n_mode = r_mode;
        n_err  = r_err;
        if (i_accept) begin
            if (i_is_last) begin
                n_mode = MODE_NORMAL;
                n_err  = ERR_NONE;
            end else begin
                n_mode = scan_mode;
                n_err  = scan_err;
            end
        end
    end

    // Output: on the last byte flag an open block comment or string
    always_comb begin
        final_err = scan_err;
        if (i_is_last && (scan_err == ERR_NONE)) begin
            priority case (scan_mode)
                MODE_BLOCK, MODE_BLOCK_STAR:          final_err = ERR_COMMENT;
                MODE_STRING, MODE_ESCAPE, MODE_ESC_CR: final_err = ERR_STRING;
                default:                              final_err = ERR_NONE;
            endcase
        end
        o_result.status        = final_err;
        o_result.final_verdict = i_is_last;
    end

    // Hold state between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_err  <= ERR_NONE;
        end else begin
            r_mode <= n_mode;
            r_err  <= n_err;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_last) |=> (r_mode == MODE_NORMAL && r_err == ERR_NONE))
        else $error("scan state not cleared after last byte");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(i_accept && i_is_last)) |=> (r_err == $past(r_err)))
        else $error("error changed inside a text");

    a_mode_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(i_accept && i_is_last)) |=> (r_mode == $past(r_mode)))
        else $error("scan advanced after an error");

    a_error_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (o_result.status == r_err))
        else $error("sticky error not reported");

endmodule

// File: rtl/jcsp_out_reg.sv
// ----------------------------------------------------------------------------
// jcsp_out_reg
// Result register between the scan logic and the output stream; takes a
// new result whenever it is empty or its content leaves in the same cycle.
// ----------------------------------------------------------------------------
module jcsp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jcsp_pkg::t_result  i_result,
    output logic               o_valid,
    input  logic               i_ready,
    output jcsp_pkg::t_result  o_result
);
    import jcsp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Accept when empty or draining this cycle
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result on a transfer in
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/json_comment_string_prescan.sv
// ----------------------------------------------------------------------------
// json_comment_string_prescan
// Lexical prescan of JSON text with comments, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per transfer in tdata, tlast on the final
//   byte of a text. Master stream: one status per byte, status in
//   tdata[1:0] (0 ok, 1 unterminated comment, 2 raw newline in string,
//   3 unterminated string), tlast set on the verdict for the whole text.
//   The status appears on the master side in the cycle after the byte
//   transfer. Throughput: one byte per cycle while the receiver does not stall;
//   the scan state is the mode and error registers, updated in the transfer cycle.
//   The first error of a text is sticky until its last byte; after the
//   last byte the scan returns to normal text with no error.
//   Reset (synchronous, active low) clears the scan state and empties the
//   result register. When the receiver stalls, the result register holds
//   and one more byte is taken only when the result leaves in that cycle.
// ----------------------------------------------------------------------------
module json_comment_string_prescan (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tlast,   // is_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] status, [7:2] zero
    output logic       o_m_axis_tlast    // final_verdict
);
    import jcsp_pkg::*;

    logic    accept;
    t_result scan_result;
    t_result out_result;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // Scan state and per-byte status
    jcsp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_s_axis_tdata),
        .i_is_last   (i_s_axis_tlast),
        .o_result    (scan_result)
    );

    // Result register toward the master side
    jcsp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_result (scan_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {(TDATA_W - 2)'(0), out_result.status};
    assign o_m_axis_tlast = out_result.final_verdict;

endmodule
